// File: rtl/imu_afp_pkg.sv
package imu_afp_pkg;

    // Frame framing bytes
    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] TYPE_BYTE = 8'h53;

    // Bytes after the type byte: eight data bytes and one sum byte
    localparam int unsigned FRAME_DATA = 9;
    localparam int unsigned STORE_DEPTH = FRAME_DATA - 1;
    localparam int unsigned IDX_W = 4;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH);

    // Angle scale: raw * 45 >>> 6 gives units of 1/128 degree
    localparam int unsigned PROD_W = 23;
    localparam logic signed [PROD_W-1:0] ANGLE_GAIN = 23'sd45;
    localparam int unsigned ANGLE_SHIFT = 6;

    // Angle range after scaling
    localparam logic signed [15:0] ANGLE_MIN = -16'sd23040;
    localparam logic signed [15:0] ANGLE_MAX = 16'sd23039;

    typedef enum logic [1:0] {
        ST_WAIT_HDR  = 2'd0,
        ST_WAIT_TYPE = 2'd1,
        ST_COLLECT   = 2'd2
    } hunt_state_t;

    // Completed frame handed from the parser to the scaler
    typedef struct packed {
        logic [STORE_DEPTH-1:0][7:0] payload;
        logic [31:0]                 byte_count;
        logic [31:0]                 frame_count;
    } frame_t;

    // One result item
    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic [15:0]        version_word;
        logic [31:0]        bytes_seen;
        logic [31:0]        good_frames;
    } result_t;

    // Little-endian raw angle to 1/128 degree, floor of raw * 45 / 64
    function automatic logic signed [15:0] scale_angle(input logic [7:0] lo,
                                                       input logic [7:0] hi);
        logic signed [PROD_W-1:0] prod;
        prod = PROD_W'($signed({hi, lo})) * ANGLE_GAIN;
        return prod[ANGLE_SHIFT +: 16];
    endfunction

endpackage

// File: rtl/imu_afp_parser.sv
module imu_afp_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    output logic                 in_ready,
    output logic                 frm_valid,
    output imu_afp_pkg::frame_t  frm,
    input  logic                 frm_ready
);
    import imu_afp_pkg::*;

    hunt_state_t      state_reg, state_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic [7:0]       sum_reg, sum_next;
    logic [31:0]      byte_cnt_reg, byte_cnt_next;
    logic [31:0]      frame_cnt_reg, frame_cnt_next;
    logic [7:0]       store_reg [STORE_DEPTH];
    logic             store_we;
    logic             frm_load;
    logic             frm_valid_reg, frm_valid_next;
    frame_t           frm_reg;
    logic             in_accept;

    // Take a byte whenever the frame slot is free or draining
    assign in_ready  = !frm_valid_reg || frm_ready;
    assign in_accept = in_valid && in_ready;

    // Hunt and collect state machine
    always_comb begin
        state_next     = state_reg;
        index_next     = index_reg;
        sum_next       = sum_reg;
        byte_cnt_next  = byte_cnt_reg;
        frame_cnt_next = frame_cnt_reg;
        store_we       = 1'b0;
        frm_load       = 1'b0;
        if (in_accept) begin
            byte_cnt_next = byte_cnt_reg + 32'd1;
            unique case (state_reg)
                ST_WAIT_HDR: begin
                    if (in_byte == HDR_BYTE) begin
                        state_next = ST_WAIT_TYPE;
                    end
                end
                ST_WAIT_TYPE: begin
                    if (in_byte == TYPE_BYTE) begin
                        state_next = ST_COLLECT;
                        index_next = '0;
                        sum_next   = HDR_BYTE + TYPE_BYTE;
                    end else if (in_byte != HDR_BYTE) begin
                        state_next = ST_WAIT_HDR;
                    end
                end
                ST_COLLECT: begin
                    if (index_reg < LAST_IDX) begin
                        store_we   = 1'b1;
                        sum_next   = sum_reg + in_byte;
                        index_next = index_reg + IDX_W'(1);
                    end else begin
                        if (sum_reg == in_byte) begin
                            frame_cnt_next = frame_cnt_reg + 32'd1;
                            frm_load       = 1'b1;
                        end
                        index_next = '0;
                        state_next = ST_WAIT_HDR;
                    end
                end
                default: begin
                    state_next = ST_WAIT_HDR;
                end
            endcase
        end
    end

    // Hold a finished frame until the scaler takes it
    always_comb begin
        if (frm_load) begin
            frm_valid_next = 1'b1;
        end else if (frm_ready) begin
            frm_valid_next = 1'b0;
        end else begin
            frm_valid_next = frm_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_WAIT_HDR;
            index_reg     <= '0;
            sum_reg       <= '0;
            byte_cnt_reg  <= '0;
            frame_cnt_reg <= '0;
            frm_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            index_reg     <= index_next;
            sum_reg       <= sum_next;
            byte_cnt_reg  <= byte_cnt_next;
            frame_cnt_reg <= frame_cnt_next;
            frm_valid_reg <= frm_valid_next;
        end
    end

    // Payload store, written one data byte per transfer
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[index_reg[2:0]] <= in_byte;
        end
    end

    // Capture the frame snapshot
    always_ff @(posedge aclk) begin
        if (frm_load) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                frm_reg.payload[i] <= store_reg[i];
            end
            frm_reg.byte_count  <= byte_cnt_next;
            frm_reg.frame_count <= frame_cnt_next;
        end
    end

    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

    // Index counts data bytes and never passes the sum position
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        index_reg <= LAST_IDX)
        else $error("payload index out of range");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && state_reg == ST_COLLECT && index_reg < LAST_IDX
        |=> index_reg == IDX_W'($past(index_reg) + IDX_W'(1)))
        else $error("payload index did not advance");

    a_frame_only_at_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && state_reg != ST_COLLECT |=> !frm_valid_reg)
        else $error("frame produced outside collect state");

    a_frame_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        frm_load |=> frame_cnt_reg == $past(frame_cnt_reg) + 32'd1)
        else $error("frame counter did not advance on good frame");

endmodule

// File: rtl/imu_afp_scaler.sv
module imu_afp_scaler (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 frm_valid,
    input  imu_afp_pkg::frame_t  frm,
    output logic                 frm_ready,
    output logic                 res_valid,
    output imu_afp_pkg::result_t res,
    input  logic                 res_ready
);
    import imu_afp_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    logic    out_load;

    // Output register frees up when empty or being taken
    assign frm_ready = !out_valid_reg || res_ready;
    assign out_load  = frm_valid && frm_ready;

    always_comb begin
        if (frm_ready) begin
            out_valid_next = frm_valid;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Scale the three angles and load the result
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.roll_angle   <= scale_angle(frm.payload[0], frm.payload[1]);
            out_reg.pitch_angle  <= scale_angle(frm.payload[2], frm.payload[3]);
            out_reg.yaw_angle    <= scale_angle(frm.payload[4], frm.payload[5]);
            out_reg.version_word <= {frm.payload[7], frm.payload[6]};
            out_reg.bytes_seen   <= frm.byte_count;
            out_reg.good_frames  <= frm.frame_count;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Scaled angles stay inside the half-turn range
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_reg.roll_angle >= ANGLE_MIN && out_reg.roll_angle <= ANGLE_MAX
            && out_reg.pitch_angle >= ANGLE_MIN && out_reg.pitch_angle <= ANGLE_MAX
            && out_reg.yaw_angle >= ANGLE_MIN && out_reg.yaw_angle <= ANGLE_MAX)
        else $error("scaled angle out of range");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        frm_valid && !frm_ready |-> out_valid_reg && !res_ready)
        else $error("frame stalled with free output register");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_valid_reg && out_reg.good_frames == $past(frm.frame_count))
        else $error("loaded frame not presented");

endmodule

// File: rtl/imu_angle_frame_parser_unit.sv
// A good frame passes the parser's frame register, then the scaler's output register.
// Throughput: one byte per cycle; the parser stage and the output register
// form a two-deep pipeline, so input stalls only while both hold a frame.
// Reset: synchronous, active low aresetn; clears hunt state, index, sum,
// both counters and the valid flags. The payload store is not reset.
module imu_angle_frame_parser_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] roll_angle, [31:16] pitch_angle, [47:32] yaw_angle,
    // [63:48] version_word, [95:64] bytes_seen, [127:96] good_frames
    output logic [127:0] m_tdata
);
    import imu_afp_pkg::*;

    logic    frm_valid;
    logic    frm_ready;
    frame_t  frm;
    result_t res;

    imu_afp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_ready  (s_tready),
        .frm_valid (frm_valid),
        .frm       (frm),
        .frm_ready (frm_ready)
    );

    imu_afp_scaler u_scaler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .frm_valid (frm_valid),
        .frm       (frm),
        .frm_ready (frm_ready),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    // Pack the result, first field in the lowest bits
    assign m_tdata = {res.good_frames, res.bytes_seen, res.version_word,
                      res.yaw_angle, res.pitch_angle, res.roll_angle};

endmodule
